// ===== rtl/hall_tach_pkg.sv =====
`default_nettype none

package hall_tach_pkg;

   // Field and register widths.
   localparam int TIME_W  = 32;
   localparam int SPEED_W = 16;
   localparam int REJ_W   = 20;
   localparam int STALL_W = 22;
   localparam int CSR_W   = 22;

   // Reset values of the configuration registers.
   localparam logic [REJ_W-1:0]   REJECT_RESET = 20'd3333;
   localparam logic [STALL_W-1:0] STALL_RESET  = 22'd500000;

   // Sensor edges per revolution; the ring spans two revolutions.
   localparam int TRIGGERS_PER_REV_DEF = 4;

   // Two revolutions expressed in microseconds times rpm.
   localparam int DVD_W = 27;
   localparam logic [DVD_W-1:0] RPM_DIVIDEND = 27'd120000000;

   localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

   // Event kinds.
   typedef enum logic {
      OP_EDGE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // Register indexes on the configuration port.
   typedef enum logic {
      CSR_REJECT = 1'b0,
      CSR_STALL  = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/hall_tach_ram.sv =====
`default_nettype none

module hall_tach_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 9
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/hall_tach_div.sv =====
`default_nettype none

// Restoring radix-2 divider of the fixed rpm dividend by a 32-bit span.
// One quotient bit per cycle; quotient bits beyond the speed width are kept
// as a sticky overflow that saturates the result. A zero span yields all ones
// in every step and therefore saturates as well.
module hall_tach_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [hall_tach_pkg::TIME_W-1:0]   divisor,
   output logic                                    done,
   output logic      [hall_tach_pkg::SPEED_W-1:0]  quotient
);

   localparam int TW  = hall_tach_pkg::TIME_W;
   localparam int SW  = hall_tach_pkg::SPEED_W;
   localparam int DW  = hall_tach_pkg::DVD_W;
   localparam int CW  = $clog2(DW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] rem_ff, rem_in;
   logic [TW-1:0] div_ff, div_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic          ovf_ff, ovf_in;

   logic [TW:0]   rem_shift;
   logic [TW:0]   rem_sub;
   logic          fits;

   always_comb begin
      rem_shift = {rem_ff, dvd_ff[DW-1]};
      rem_sub   = rem_shift - {1'b0, div_ff};
      fits      = rem_shift >= {1'b0, div_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;

      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         dvd_in  = hall_tach_pkg::RPM_DIVIDEND;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[TW-1:0] : rem_shift[TW-1:0];
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         quo_in = {quo_ff[SW-2:0], fits};
         ovf_in = ovf_ff | quo_ff[SW-1];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = ovf_ff ? hall_tach_pkg::SPEED_MAX : quo_ff;

endmodule

`default_nettype wire

// ===== rtl/hall_tachometer_with_glitch_reject.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_op, req_time_us
// rsp       out        rsp_valid/rsp_stall  rsp_speed_rpm, rsp_edge_accepted
// csr       in         csr_write            csr_index, csr_wdata
//
// A sensor edge and a tick without a pending edge each take one bit-serial
// pass over the 32-bit timestamps. A tick with a pending edge adds two ring
// reads before the serial pass and a 27-step divider after it that produces
// one quotient bit per cycle. Reset is synchronous and clears the state, the
// ring valid bits and the configuration registers to their defaults. A
// stalled result waits in the output register while the next transaction is
// already accepted.
`default_nettype none

module hall_tachometer_with_glitch_reject #(
   parameter int TRIGGERS_PER_REV = hall_tach_pkg::TRIGGERS_PER_REV_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Event input.
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_op,
   input  wire logic [hall_tach_pkg::TIME_W-1:0]    req_time_us,
   // Result output.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [hall_tach_pkg::SPEED_W-1:0]   rsp_speed_rpm,
   output logic                                     rsp_edge_accepted,
   // Configuration writes.
   input  wire logic                                csr_write,
   input  wire logic                                csr_index,
   input  wire logic [hall_tach_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int TW         = hall_tach_pkg::TIME_W;
   localparam int SW         = hall_tach_pkg::SPEED_W;
   localparam int RW         = hall_tach_pkg::REJ_W;
   localparam int STW        = hall_tach_pkg::STALL_W;
   localparam int RING_DEPTH = 2 * TRIGGERS_PER_REV + 1;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int BIT_W      = $clog2(TW);

   // One-hot sequencer. A tick with a pending edge reads the newest and the
   // oldest stamp from the ring before the serial pass and divides after it.
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_RD_NEW = 6'b000010,
      S_RD_OLD = 6'b000100,
      S_RD_CAP = 6'b001000,
      S_SERIAL = 6'b010000,
      S_DIVIDE = 6'b100000
   } state_type;

   // The finish step is folded into a flag so the result can wait for room
   // in the output register without an extra state.
   state_type        state_ff, state_in;
   logic             finish_ff, finish_in;

   // Configuration.
   logic [RW-1:0]    reject_ff, reject_in;
   logic [STW-1:0]   stall_ff, stall_in;

   // Architectural state.
   logic [IDX_W-1:0]      ring_index_ff, ring_index_in;
   logic [TW-1:0]         last_accept_ff, last_accept_in;
   logic                  pending_ff, pending_in;
   logic [SW-1:0]         speed_ff, speed_in;
   logic [RING_DEPTH-1:0] valid_ff, valid_in;

   // Current transaction.
   logic             op_ff;
   logic [TW-1:0]    time_ff;
   logic             calc_ff, calc_in;

   // Bit-serial datapath: shift registers feed one bit per cycle, LSB first.
   logic [TW-1:0]    ta_sh_ff, ta_sh_in;     // event time
   logic [TW-1:0]    tb_sh_ff, tb_sh_in;     // last accepted time
   logic [TW-1:0]    new_sh_ff, new_sh_in;   // newest ring stamp
   logic [TW-1:0]    old_sh_ff, old_sh_in;   // oldest ring stamp
   logic [TW-1:0]    span_ff, span_in;       // newest minus oldest, built MSB in
   logic             bor_t_ff, bor_t_in;
   logic             bor_s_ff, bor_s_in;
   logic             gt_rej_ff, gt_rej_in;
   logic             gt_stall_ff, gt_stall_in;
   logic [BIT_W-1:0] bit_cnt_ff, bit_cnt_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]    rsp_speed_ff, rsp_speed_in;
   logic             rsp_acc_ff, rsp_acc_in;

   // Ring memory interface.
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [TW-1:0]    ram_rd_data;
   logic             rd_valid_ff;

   // Divider interface.
   logic             div_start;
   logic             div_done;
   logic [SW-1:0]    div_quotient;

   logic             req_take;
   logic             slot_free;
   logic [IDX_W-1:0] index_next;
   logic [TW-1:0]    rej_ext;
   logic [TW-1:0]    stall_ext;
   logic             a_bit, b_bit, d_bit;
   logic             n_bit, o_bit, s_bit;
   logic             r_bit, t_bit;
   logic             last_bit;
   logic             edge_ok;

   assign req_stall = reset | (state_ff != S_IDLE) | finish_ff;
   assign req_take  = req_valid & !req_stall;
   assign slot_free = !rsp_valid_ff | !rsp_stall;

   // The slot after the newest entry holds the oldest stamp of the ring and
   // is also the slot that the next accepted edge overwrites.
   assign index_next = (ring_index_ff == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                 : ring_index_ff + 1'b1;

   assign rej_ext   = {{(TW - RW){1'b0}}, reject_ff};
   assign stall_ext = {{(TW - STW){1'b0}}, stall_ff};

   assign last_bit = (bit_cnt_ff == BIT_W'(TW - 1));
   assign edge_ok  = (op_ff == hall_tach_pkg::OP_EDGE) & gt_rej_ff;

   assign ram_rd_addr = (state_ff == S_RD_NEW) ? ring_index_ff : index_next;
   assign ram_wr_en   = finish_ff & slot_free & edge_ok;

   hall_tach_ram #(
      .WIDTH (TW),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (index_next),
      .wr_data (time_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hall_tach_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (span_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      // Serial bits of this cycle.
      a_bit = ta_sh_ff[0];
      b_bit = tb_sh_ff[0];
      d_bit = a_bit ^ b_bit ^ bor_t_ff;
      n_bit = new_sh_ff[0];
      o_bit = old_sh_ff[0];
      s_bit = n_bit ^ o_bit ^ bor_s_ff;
      r_bit = rej_ext[bit_cnt_ff];
      t_bit = stall_ext[bit_cnt_ff];

      state_in       = state_ff;
      finish_in      = finish_ff;
      reject_in      = reject_ff;
      stall_in       = stall_ff;
      ring_index_in  = ring_index_ff;
      last_accept_in = last_accept_ff;
      pending_in     = pending_ff;
      speed_in       = speed_ff;
      valid_in       = valid_ff;
      calc_in        = calc_ff;
      ta_sh_in       = ta_sh_ff;
      tb_sh_in       = tb_sh_ff;
      new_sh_in      = new_sh_ff;
      old_sh_in      = old_sh_ff;
      span_in        = span_ff;
      bor_t_in       = bor_t_ff;
      bor_s_in       = bor_s_ff;
      gt_rej_in      = gt_rej_ff;
      gt_stall_in    = gt_stall_ff;
      bit_cnt_in     = bit_cnt_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_speed_in   = rsp_speed_ff;
      rsp_acc_in     = rsp_acc_ff;
      div_start      = 1'b0;

      // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
      if (csr_write) begin
         case (csr_index)
            hall_tach_pkg::CSR_REJECT: reject_in = csr_wdata[RW-1:0];
            hall_tach_pkg::CSR_STALL:  stall_in  = csr_wdata[STW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               ta_sh_in    = req_time_us;
               tb_sh_in    = last_accept_ff;
               new_sh_in   = '0;
               old_sh_in   = '0;
               bor_t_in    = 1'b0;
               bor_s_in    = 1'b0;
               gt_rej_in   = 1'b0;
               gt_stall_in = 1'b0;
               bit_cnt_in  = '0;
               calc_in     = (req_op == hall_tach_pkg::OP_TICK) & pending_ff;
               state_in    = ((req_op == hall_tach_pkg::OP_TICK) && pending_ff) ? S_RD_NEW
                                                                               : S_SERIAL;
            end
         end
         S_RD_NEW: begin
            state_in = S_RD_OLD;
         end
         S_RD_OLD: begin
            // Entries never written since reset read as zero.
            new_sh_in = rd_valid_ff ? ram_rd_data : '0;
            state_in  = S_RD_CAP;
         end
         S_RD_CAP: begin
            old_sh_in = rd_valid_ff ? ram_rd_data : '0;
            state_in  = S_SERIAL;
         end
         S_SERIAL: begin
            ta_sh_in    = {1'b0, ta_sh_ff[TW-1:1]};
            tb_sh_in    = {1'b0, tb_sh_ff[TW-1:1]};
            new_sh_in   = {1'b0, new_sh_ff[TW-1:1]};
            old_sh_in   = {1'b0, old_sh_ff[TW-1:1]};
            bor_t_in    = (!a_bit & b_bit) | (!(a_bit ^ b_bit) & bor_t_ff);
            bor_s_in    = (!n_bit & o_bit) | (!(n_bit ^ o_bit) & bor_s_ff);
            span_in     = {s_bit, span_ff[TW-1:1]};
            // Strictly-greater compares, decided by the highest differing bit.
            gt_rej_in   = (d_bit & !r_bit) | (!(d_bit ^ r_bit) & gt_rej_ff);
            gt_stall_in = (d_bit & !t_bit) | (!(d_bit ^ t_bit) & gt_stall_ff);
            bit_cnt_in  = bit_cnt_ff + 1'b1;
            if (last_bit) begin
               if (calc_ff) begin
                  div_start = 1'b1;
                  state_in  = S_DIVIDE;
               end else begin
                  state_in  = S_IDLE;
                  finish_in = 1'b1;
               end
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               state_in  = S_IDLE;
               finish_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Commit the transaction once the output register has room.
      if (finish_ff && slot_free) begin
         finish_in    = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_acc_in   = edge_ok;
         if (op_ff == hall_tach_pkg::OP_EDGE) begin
            rsp_speed_in = speed_ff;
            if (gt_rej_ff) begin
               ring_index_in       = index_next;
               last_accept_in      = time_ff;
               pending_in          = 1'b1;
               valid_in[index_next] = 1'b1;
            end
         end else begin
            pending_in = 1'b0;
            speed_in   = gt_stall_ff ? '0 : (calc_ff ? div_quotient : speed_ff);
            rsp_speed_in = speed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         finish_ff      <= 1'b0;
         reject_ff      <= hall_tach_pkg::REJECT_RESET;
         stall_ff       <= hall_tach_pkg::STALL_RESET;
         ring_index_ff  <= '0;
         last_accept_ff <= '0;
         pending_ff     <= 1'b0;
         speed_ff       <= '0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         calc_ff        <= 1'b0;
         bit_cnt_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         finish_ff      <= finish_in;
         reject_ff      <= reject_in;
         stall_ff       <= stall_in;
         ring_index_ff  <= ring_index_in;
         last_accept_ff <= last_accept_in;
         pending_ff     <= pending_in;
         speed_ff       <= speed_in;
         valid_ff       <= valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         calc_ff        <= calc_in;
         bit_cnt_ff     <= bit_cnt_in;
      end
      if (req_take) begin
         op_ff   <= req_op;
         time_ff <= req_time_us;
      end
      ta_sh_ff     <= ta_sh_in;
      tb_sh_ff     <= tb_sh_in;
      new_sh_ff    <= new_sh_in;
      old_sh_ff    <= old_sh_in;
      span_ff      <= span_in;
      bor_t_ff     <= bor_t_in;
      bor_s_ff     <= bor_s_in;
      gt_rej_ff    <= gt_rej_in;
      gt_stall_ff  <= gt_stall_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_acc_ff   <= rsp_acc_in;
      rd_valid_ff  <= valid_ff[ram_rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed_rpm     = rsp_speed_ff;
   assign rsp_edge_accepted = rsp_acc_ff;

endmodule

`default_nettype wire

// ===== rtl/hall_tach_chk.sv =====
`default_nettype none

module hall_tach_chk (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [hall_tach_pkg::SPEED_W-1:0]  rsp_speed_rpm,
   input wire logic                               rsp_edge_accepted
);

   // Speed of the last delivered result; an accepted edge leaves it unchanged.
   logic [hall_tach_pkg::SPEED_W-1:0] last_speed_ff, last_speed_in;

   assign last_speed_in = (rsp_valid && !rsp_stall) ? rsp_speed_rpm : last_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_speed_ff <= '0;
      end else begin
         last_speed_ff <= last_speed_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_speed_rpm)
                                 && $stable(rsp_edge_accepted))
      else $error("stalled result changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result presented right after reset");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken in back-to-back cycles");

   a_edge_keeps_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_edge_accepted |-> rsp_speed_rpm == last_speed_ff)
      else $error("accepted edge changed the reported speed");

endmodule

bind hall_tachometer_with_glitch_reject hall_tach_chk u_hall_tach_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_speed_rpm     (rsp_speed_rpm),
   .rsp_edge_accepted (rsp_edge_accepted)
);

`default_nettype wire
